@@ hdl/pkrh_pkg.sv @@
// Package for the per-key reply hold-off table.
// Holds table sizing, action and register codes and the slot word layout.
// No dependencies.
package pkrh_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int KEY_W         = 32;
   localparam int DELAY_W       = 16;
   localparam int ENTRIES_W     = 5;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;

   typedef enum logic [0:0] {
      ACT_MESSAGE = 1'b0,
      ACT_TICK    = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLED     = 1'b0,
      REG_REPLY_DELAY = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DELAY_W-1:0] remaining;
      logic [DELAY_W-1:0] delay;
   } slot_type;

endpackage

@@ hdl/pkrh_if.sv @@
// Handshake channels of the per-key reply hold-off table.
// Request, response and register write channels; depends on pkrh_pkg.
interface pkrh_req_if;
   logic                         valid;
   logic                         ready;
   logic [0:0]                   action;
   logic [pkrh_pkg::KEY_W-1:0]   contact_key;

   modport source (output valid, output action, output contact_key, input ready);
   modport sink   (input valid, input action, input contact_key, output ready);
endinterface

interface pkrh_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             allowed;
   logic                             table_full;
   logic [pkrh_pkg::ENTRIES_W-1:0]   entries_in_use;

   modport source (output valid, output allowed, output table_full,
                   output entries_in_use, input ready);
   modport sink   (input valid, input allowed, input table_full,
                   input entries_in_use, output ready);
endinterface

interface pkrh_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pkrh_pkg::CSR_IDX_W-1:0]    index;
   logic [pkrh_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/pkrh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pkrh_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

@@ hdl/per_key_reply_holdoff_table_top.sv @@
// Top level of the per-key reply hold-off table.
// Depends on pkrh_pkg, the channel interfaces in pkrh_if and pkrh_ram.
//
// Keys, countdowns and delays live in one RAM of TABLE_ENTRIES words; valid
// bits and the entry count sit in flip-flops and are cleared by reset, so no
// clearing pass is needed. A tick or an enabled message sweeps the RAM one
// slot per cycle: the item is taken in the idle state, the scan state reads
// every slot, the last state evaluates the last read and the commit state
// commits and registers the result. A message while disabled goes from idle
// straight to commit without a sweep. Ticks age and expire entries during
// the sweep itself; a message is matched during the sweep and written back
// in the commit state. The lowest free slot takes a new key. A result waits
// in its output register and the block stalls at commit only while that
// register is full. Register writes are always taken.
module per_key_reply_holdoff_table_top (
   input  logic              clock,
   input  logic              reset,
   pkrh_req_if.sink          req_chan,
   pkrh_rsp_if.source        rsp_chan,
   pkrh_csr_if.sink          csr_chan
);
   localparam int N = pkrh_pkg::TABLE_ENTRIES;
   localparam logic [pkrh_pkg::IDX_W-1:0] LAST_IDX = pkrh_pkg::IDX_W'(N - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT
   } state_type;

   state_type                        state_ff,    state_in;
   logic [pkrh_pkg::IDX_W-1:0]       idx_ff,      idx_in;
   logic                             eval_vld_ff, eval_vld_in;
   logic [pkrh_pkg::IDX_W-1:0]       eval_idx_ff, eval_idx_in;
   logic                             tick_ff,     tick_in;
   logic                             en_msg_ff,   en_msg_in;
   logic [pkrh_pkg::KEY_W-1:0]       key_ff,      key_in;
   logic                             hit_ff,      hit_in;
   logic [pkrh_pkg::IDX_W-1:0]       hit_idx_ff,  hit_idx_in;
   logic [pkrh_pkg::DELAY_W-1:0]     hit_dly_ff,  hit_dly_in;
   logic                             free_ff,     free_in;
   logic [pkrh_pkg::IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [N-1:0]                     valid_ff,    valid_in;
   logic [pkrh_pkg::CNT_W-1:0]       cnt_ff,      cnt_in;
   logic                             rsp_vld_ff,  rsp_vld_in;
   logic                             allow_ff,    allow_in;
   logic                             full_ff,     full_in;
   logic [pkrh_pkg::ENTRIES_W-1:0]   used_ff,     used_in;
   logic                             enabled_ff,  enabled_in;
   logic [pkrh_pkg::DELAY_W-1:0]     delay_ff,    delay_in;

   logic                             wr_en;
   logic [pkrh_pkg::IDX_W-1:0]       wr_addr;
   pkrh_pkg::slot_type               wr_data;
   logic                             rd_en;
   pkrh_pkg::slot_type               rd_data;
   logic [pkrh_pkg::DELAY_W-1:0]     rem_dec;
   logic                             out_free;

   pkrh_ram #(
      .WIDTH ($bits(pkrh_pkg::slot_type)),
      .DEPTH (N)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.allowed        = allow_ff;
   assign rsp_chan.table_full     = full_ff;
   assign rsp_chan.entries_in_use = used_ff;

   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign rd_en    = (state_ff == ST_SCAN);
   assign rem_dec  = rd_data.remaining - pkrh_pkg::DELAY_W'(rd_data.remaining != '0);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      eval_vld_in = 1'b0;
      eval_idx_in = idx_ff;
      tick_in     = tick_ff;
      en_msg_in   = en_msg_ff;
      key_in      = key_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_dly_in  = hit_dly_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      allow_in    = allow_ff;
      full_in     = full_ff;
      used_in     = used_ff;
      enabled_in  = enabled_ff;
      delay_in    = delay_ff;
      wr_en       = 1'b0;
      wr_addr     = eval_idx_ff;
      wr_data     = '{key: rd_data.key, remaining: rem_dec, delay: rd_data.delay};

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            pkrh_pkg::REG_ENABLED:     enabled_in = csr_chan.wdata[0];
            pkrh_pkg::REG_REPLY_DELAY: delay_in   = csr_chan.wdata;
            default:                   ;
         endcase
      end

      // Evaluate the slot read in the previous cycle.
      if (eval_vld_ff) begin
         if (tick_ff) begin
            if (valid_ff[eval_idx_ff]) begin
               wr_en = 1'b1;
               if (rem_dec == '0) begin
                  valid_in[eval_idx_ff] = 1'b0;
                  cnt_in                = cnt_ff - 1'b1;
               end
            end
         end else if (valid_ff[eval_idx_ff]) begin
            if (!hit_ff && rd_data.key == key_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = eval_idx_ff;
               hit_dly_in = rd_data.delay;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = eval_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               tick_in   = (req_chan.action == pkrh_pkg::ACT_TICK);
               en_msg_in = (req_chan.action == pkrh_pkg::ACT_MESSAGE) && enabled_ff;
               key_in    = req_chan.contact_key;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               idx_in    = '0;
               if (req_chan.action == pkrh_pkg::ACT_TICK || enabled_ff) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SCAN: begin
            eval_vld_in = 1'b1;
            eval_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               allow_in = 1'b0;
               full_in  = 1'b0;
               if (en_msg_ff) begin
                  if (hit_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = hit_idx_ff;
                     wr_data = '{key: key_ff, remaining: hit_dly_ff, delay: hit_dly_ff};
                  end else if (free_ff) begin
                     wr_en                 = 1'b1;
                     wr_addr               = free_idx_ff;
                     wr_data               = '{key: key_ff, remaining: delay_ff,
                                               delay: delay_ff};
                     valid_in[free_idx_ff] = 1'b1;
                     cnt_in                = cnt_ff + 1'b1;
                     allow_in              = 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               used_in    = pkrh_pkg::ENTRIES_W'(cnt_in);
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         eval_vld_ff <= 1'b0;
         valid_ff    <= '0;
         cnt_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
         enabled_ff  <= 1'b0;
         delay_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= eval_vld_in;
         valid_ff    <= valid_in;
         cnt_ff      <= cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
         enabled_ff  <= enabled_in;
         delay_ff    <= delay_in;
      end
      idx_ff      <= idx_in;
      eval_idx_ff <= eval_idx_in;
      tick_ff     <= tick_in;
      en_msg_ff   <= en_msg_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_dly_ff  <= hit_dly_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      allow_ff    <= allow_in;
      full_ff     <= full_in;
      used_ff     <= used_in;
   end
endmodule
